// ===== rtl/core/additive_lagged_random_generator_core_assert.svh =====
// Assertion macros for the lagged-additive generator core.
// Both macros check at the rising edge of the given clock and are disabled while
// the active-low reset is asserted.
`ifndef ADDITIVE_LAGGED_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define ADDITIVE_LAGGED_RANDOM_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ALRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ALRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ALRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ALRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/alrg_pkg.sv =====
package alrg_pkg;

    localparam int WORD_W            = 32;
    localparam int RING_LEN          = 56;
    localparam int PTR_W             = $clog2(RING_LEN);
    // The second lag sits 55 - 24 places ahead of the first lag.
    localparam int SECOND_LAG_OFFSET = 55 - 24;
    localparam int FILL_MULT         = 3;
    localparam int FILL_ADD          = 257;
    localparam int WARMUP_DRAWS      = 10000;
    localparam int RETRY_LIMIT       = 10000;
    localparam int LOOP_MAX          = (WARMUP_DRAWS > RETRY_LIMIT) ? WARMUP_DRAWS : RETRY_LIMIT;
    localparam int CNT_W             = $clog2(LOOP_MAX + 2);

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] seed_value;
        logic [WORD_W-1:0] range_size;
    } alrg_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              not_seeded;
        logic              gave_up;
    } alrg_out_t;

    typedef enum logic [1:0] {
        RES_ACK,
        RES_NOT_SEEDED,
        RES_GAVE_UP,
        RES_DRAW
    } res_kind_t;

    typedef enum logic {
        DIV_SRC_LIMIT,
        DIV_SRC_VALUE
    } div_src_t;

    typedef struct packed {
        logic      load_req;
        logic      fill_step;
        logic      ptr_init;
        logic      ring_wr;
        logic      div_start;
        div_src_t  div_src;
        logic      cap_divisor;
        logic      mul_load;
        logic      res_load;
        res_kind_t res_kind;
    } alrg_cmd_t;

    typedef struct packed {
        logic req_draw;
        logic req_big;
        logic fill_last;
        logic warm_done;
        logic retry_over;
        logic reject;
        logic size_big;
        logic div_done;
    } alrg_stat_t;

endpackage

// ===== rtl/core/additive_lagged_random_generator_core.sv =====
// Lagged-additive random generator over a 56-word ring held in a small RAM. A
// seed transfer fills the ring and then runs the 10000 warm-up draws, each as
// a RAM read step followed by an add and write-back step, before its
// acknowledge appears. A draw with a range of 0 or 1 reads, writes back and
// loads the result. A draw with a larger range uses the serial divider to form
// the divisor, then a multiply step, a read and a write-back step per attempt,
// a second division for the final quotient and a result step, with at most
// 10001 attempts (a draw that gives up skips the final division). The block
// takes one request at a time; a finished result waits in an output register.
`include "additive_lagged_random_generator_core_assert.svh"

module additive_lagged_random_generator_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  alrg_pkg::alrg_in_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output alrg_pkg::alrg_out_t rsp
);

    import alrg_pkg::*;

    alrg_cmd_t  cmd;
    alrg_stat_t stat;

    alrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    alrg_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

    `ALRG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted while busy")
    `ALRG_ASSERT_SAME(a_no_result_overwrite, clk, rst_n, cmd.res_load, !rsp_valid || rsp_ready, "result register overwritten")
    `ALRG_ASSERT_SAME(a_flag_value_zero, clk, rst_n, rsp_valid && (rsp.gave_up || rsp.not_seeded), rsp.value == '0, "flagged result has nonzero value")

endmodule

// ===== rtl/core/alrg_ram.sv =====
module alrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 56
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/alrg_div.sv =====
module alrg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [alrg_pkg::WORD_W-1:0]   dividend,
    input  logic [alrg_pkg::WORD_W-1:0]   divisor,
    output logic                          done,
    output logic [alrg_pkg::WORD_W-1:0]   quotient
);

    import alrg_pkg::*;

    localparam int STEP_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            step_next = STEP_W'(WORD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/alrg_datapath.sv =====
module alrg_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alrg_pkg::alrg_in_t   req,
    input  alrg_pkg::alrg_cmd_t  cmd,
    output alrg_pkg::alrg_stat_t stat,
    output alrg_pkg::alrg_out_t  rsp
);

    import alrg_pkg::*;

    logic [PTR_W-1:0]    lag_ptr_reg, lag_ptr_next;
    logic [PTR_W-1:0]    fill_idx_reg, fill_idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [WORD_W-1:0]   fill_val_reg, fill_val_next;
    logic [WORD_W-1:0]   size_reg, size_next;
    logic [WORD_W-1:0]   divisor_reg, divisor_next;
    logic [WORD_W-1:0]   product_reg, product_next;
    logic [WORD_W-1:0]   sum_reg, sum_next;
    alrg_out_t           rsp_reg, rsp_next;
    logic [PTR_W-1:0]    second_ptr;
    logic [2*WORD_W-1:0] product_full;
    logic [WORD_W-1:0]   sum;
    logic                ram_wr_en;
    logic [PTR_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic [WORD_W-1:0]   rd_data_a;
    logic [WORD_W-1:0]   rd_data_b;
    logic [WORD_W-1:0]   div_dividend;
    logic [WORD_W-1:0]   div_divisor;
    logic                div_done;
    logic [WORD_W-1:0]   div_quotient;

    // The write pointer is the first-lag pointer itself, so a draw
    // writes its sum back over the first-lag word that it has just read.
    assign second_ptr = (lag_ptr_reg < PTR_W'(RING_LEN - SECOND_LAG_OFFSET))
                      ? lag_ptr_reg + PTR_W'(SECOND_LAG_OFFSET)
                      : lag_ptr_reg - PTR_W'(RING_LEN - SECOND_LAG_OFFSET);

    assign sum          = rd_data_a + rd_data_b;
    assign product_full = size_reg * divisor_reg;

    assign ram_wr_en   = cmd.fill_step || cmd.ring_wr;
    assign ram_wr_addr = cmd.fill_step ? fill_idx_reg : lag_ptr_reg;
    assign ram_wr_data = cmd.fill_step ? fill_val_reg : sum;

    alrg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_LEN)
    ) u_ring (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (lag_ptr_reg),
        .rd_addr_b (second_ptr),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign div_dividend = (cmd.div_src == DIV_SRC_LIMIT) ? {WORD_W{1'b1}} : sum;
    assign div_divisor  = (cmd.div_src == DIV_SRC_LIMIT) ? req.range_size : divisor_reg;

    alrg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        lag_ptr_next  = lag_ptr_reg;
        fill_idx_next = fill_idx_reg;
        cnt_next      = cnt_reg;
        fill_val_next = fill_val_reg;
        size_next     = size_reg;
        divisor_next  = divisor_reg;
        product_next  = product_reg;
        sum_next      = sum_reg;
        rsp_next      = rsp_reg;

        if (cmd.load_req)
        begin
            size_next     = req.range_size;
            fill_val_next = req.seed_value;
            fill_idx_next = '0;
            cnt_next      = '0;
        end
        if (cmd.fill_step)
        begin
            fill_val_next = fill_val_reg * WORD_W'(FILL_MULT) + WORD_W'(FILL_ADD);
            fill_idx_next = fill_idx_reg + PTR_W'(1);
        end
        if (cmd.ptr_init)
        begin
            lag_ptr_next = '0;
        end
        if (cmd.ring_wr)
        begin
            sum_next     = sum;
            cnt_next     = cnt_reg + CNT_W'(1);
            lag_ptr_next = (lag_ptr_reg == PTR_W'(RING_LEN - 1))
                         ? '0 : lag_ptr_reg + PTR_W'(1);
        end
        if (cmd.cap_divisor)
        begin
            divisor_next = div_quotient;
        end
        if (cmd.mul_load)
        begin
            product_next = product_full[WORD_W-1:0];
        end
        if (cmd.res_load)
        begin
            rsp_next = '0;
            case (cmd.res_kind)
                RES_NOT_SEEDED: rsp_next.not_seeded = 1'b1;
                RES_GAVE_UP:    rsp_next.gave_up    = 1'b1;
                RES_DRAW:
                begin
                    if (size_reg > WORD_W'(1))
                    begin
                        rsp_next.value = div_quotient;
                    end
                    else if (size_reg == '0)
                    begin
                        rsp_next.value = sum_reg;
                    end
                end
                default: rsp_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_ptr_reg  <= '0;
            fill_idx_reg <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            lag_ptr_reg  <= lag_ptr_next;
            fill_idx_reg <= fill_idx_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_val_reg <= fill_val_next;
        size_reg     <= size_next;
        divisor_reg  <= divisor_next;
        product_reg  <= product_next;
        sum_reg      <= sum_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        stat            = '0;
        stat.req_draw   = (req.kind == KIND_DRAW);
        stat.req_big    = (req.range_size > WORD_W'(1));
        stat.fill_last  = (fill_idx_reg == PTR_W'(RING_LEN - 1));
        stat.warm_done  = (cnt_reg == CNT_W'(WARMUP_DRAWS));
        // Checked on the attempt being written, before its count is added.
        stat.retry_over = (cnt_reg >= CNT_W'(RETRY_LIMIT));
        stat.reject     = (sum >= product_reg);
        stat.size_big   = (size_reg > WORD_W'(1));
        stat.div_done   = div_done;
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/core/alrg_ctrl.sv =====
module alrg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  alrg_pkg::alrg_stat_t stat,
    output alrg_pkg::alrg_cmd_t  cmd
);

    import alrg_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_FILL    = 10'b00_0000_0010,
        ST_WARM_RD = 10'b00_0000_0100,
        ST_WARM_WR = 10'b00_0000_1000,
        ST_DIV_LIM = 10'b00_0001_0000,
        ST_MUL     = 10'b00_0010_0000,
        ST_DRAW_RD = 10'b00_0100_0000,
        ST_DRAW_WR = 10'b00_1000_0000,
        ST_DIV_VAL = 10'b01_0000_0000,
        ST_RESULT  = 10'b10_0000_0000
    } state_t;

    state_t    state_reg, state_next;
    logic      seeded_reg, seeded_next;
    logic      rsp_valid_reg, rsp_valid_next;
    res_kind_t res_kind_reg, res_kind_next;
    logic      req_xfer;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        res_kind_next  = res_kind_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        cmd.res_kind   = res_kind_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    cmd.load_req = 1'b1;
                    if (!stat.req_draw)
                    begin
                        seeded_next = 1'b1;
                        state_next  = ST_FILL;
                    end
                    else if (!seeded_reg)
                    begin
                        res_kind_next = RES_NOT_SEEDED;
                        state_next    = ST_RESULT;
                    end
                    else if (stat.req_big)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_src   = DIV_SRC_LIMIT;
                        state_next    = ST_DIV_LIM;
                    end
                    else
                    begin
                        state_next = ST_DRAW_RD;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.ptr_init = 1'b1;
                    state_next   = ST_WARM_RD;
                end
            end
            ST_WARM_RD:
            begin
                if (stat.warm_done)
                begin
                    res_kind_next = RES_ACK;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    state_next = ST_WARM_WR;
                end
            end
            ST_WARM_WR:
            begin
                cmd.ring_wr = 1'b1;
                state_next  = ST_WARM_RD;
            end
            ST_DIV_LIM:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_divisor = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_DRAW_RD;
            end
            ST_DRAW_RD:
            begin
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                cmd.ring_wr = 1'b1;
                if (stat.retry_over)
                begin
                    res_kind_next = RES_GAVE_UP;
                    state_next    = ST_RESULT;
                end
                else if (stat.size_big && stat.reject)
                begin
                    state_next = ST_DRAW_RD;
                end
                else if (stat.size_big)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_SRC_VALUE;
                    state_next    = ST_DIV_VAL;
                end
                else
                begin
                    res_kind_next = RES_DRAW;
                    state_next    = ST_RESULT;
                end
            end
            ST_DIV_VAL:
            begin
                if (stat.div_done)
                begin
                    res_kind_next = RES_DRAW;
                    state_next    = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Wait until the output register is empty or being emptied.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.res_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            res_kind_reg  <= RES_ACK;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            rsp_valid_reg <= rsp_valid_next;
            res_kind_reg  <= res_kind_next;
        end
    end

endmodule
